// File: sv/epdm_pkg.sv
// package for the echo pulse distance meter
// holds widths, reset values, register indexes and digit constants; no dependencies
package epdm_pkg;

  localparam int unsigned TICK_W  = 16;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned DIST_W  = 10;
  localparam int unsigned CHAR_W  = 6;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned REM_W   = 7;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [TICK_W-1:0]  PERIOD_TOP_RST = 16'd50000;
  localparam logic [SCALE_W-1:0] SCALE_Q16_RST  = 16'd1122;
  localparam logic [DIST_W-1:0]  DIST_MAX       = 10'd999;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO     = 6'h30;

  // x / 100 == (x * 41) >> 12 for x < 1000, x / 10 == (x * 103) >> 10 for x < 100
  localparam logic [5:0] DIV100_MUL = 6'd41;
  localparam int unsigned DIV100_SHR = 12;
  localparam logic [6:0] DIV10_MUL  = 7'd103;
  localparam int unsigned DIV10_SHR  = 10;
  localparam logic [6:0] HUNDRED    = 7'd100;
  localparam logic [3:0] TEN        = 4'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD_TOP = 1'b0,
    REG_SCALE_Q16  = 1'b1
  } cfg_reg_t;

endpackage

// File: sv/epdm_if.sv
// channel interfaces for the echo pulse distance meter
// uses epdm_pkg for field widths
interface epdm_echo_if;
  import epdm_pkg::*;
  logic valid;
  logic ready;
  logic echo_level;
  modport source (output valid, output echo_level, input ready);
  modport sink   (input valid, input echo_level, output ready);
endinterface

interface epdm_result_if;
  import epdm_pkg::*;
  logic                valid;
  logic                ready;
  logic [TICK_W-1:0]   elapsed_ticks;
  logic [DIST_W-1:0]   distance_cm;
  logic [CHAR_W-1:0]   hundreds_char;
  logic [CHAR_W-1:0]   tens_char;
  logic [CHAR_W-1:0]   units_char;
  modport source (output valid, output elapsed_ticks, output distance_cm,
                  output hundreds_char, output tens_char, output units_char, input ready);
  modport sink   (input valid, input elapsed_ticks, input distance_cm,
                  input hundreds_char, input tens_char, input units_char, output ready);
endinterface

interface epdm_cfg_if;
  import epdm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/echo_pulse_distance_meter_core.sv
// echo pulse distance meter: edge detect, tick counter and a four-stage result pipeline
// result path: stages a, b, c and the output register lie between the falling-edge transaction and meas.valid
// throughput: one echo transaction per cycle; the input stalls only when the
// first pipeline stage holds a result the downstream stages cannot take
// reset: synchronous rst clears state, pipeline valids and restores register defaults
// depends on epdm_pkg and the interfaces in epdm_if.sv
module echo_pulse_distance_meter_core
  import epdm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  epdm_cfg_if.sink      cfg,
  epdm_echo_if.sink     tick,
  epdm_result_if.source meas
);

  logic [TICK_W-1:0]  period_top;
  logic [SCALE_W-1:0] scale_q16;

  logic               measuring;
  logic [TICK_W-1:0]  tick_count;
  logic               last_echo;

  // stage a: captured ticks
  logic               a_valid;
  logic [TICK_W-1:0]  a_ticks;
  // stage b: product
  logic               b_valid;
  logic [TICK_W-1:0]  b_ticks;
  logic [TICK_W+SCALE_W-1:0] b_prod;
  // stage c: distance, hundreds digit, remainder
  logic               c_valid;
  logic [TICK_W-1:0]  c_ticks;
  logic [DIST_W-1:0]  c_dist;
  logic [DIGIT_W-1:0] c_hund;
  logic [REM_W-1:0]   c_rem;
  // output register
  logic               o_valid;

  logic ready_o, ready_c, ready_b, ready_a;
  logic in_fire, rising, falling;
  logic [TICK_W-1:0]  count_next;
  logic [TICK_W-1:0]  dist_full;
  logic [DIST_W-1:0]  dist_sat;
  logic [DIST_W+5:0]  hund_prod;
  logic [DIGIT_W-1:0] hund_digit;
  logic [REM_W-1:0]   rem_val;
  logic [2*REM_W-1:0] tens_prod;
  logic [DIGIT_W-1:0] tens_digit;
  logic [DIGIT_W-1:0] units_digit;

  assign ready_o = !o_valid || meas.ready;
  assign ready_c = !c_valid || ready_o;
  assign ready_b = !b_valid || ready_c;
  assign ready_a = !a_valid || ready_b;

  assign tick.ready = ready_a;
  assign cfg.ready  = 1'b1;
  assign meas.valid = o_valid;

  assign in_fire = tick.valid && tick.ready;
  assign rising  = tick.echo_level && !last_echo;
  assign falling = !tick.echo_level && last_echo;

  assign count_next = (tick_count >= period_top) ? '0 : tick_count + 1'b1;

  assign dist_full  = b_prod[TICK_W+SCALE_W-1:SCALE_W];
  assign dist_sat   = (dist_full > TICK_W'(DIST_MAX)) ? DIST_MAX : dist_full[DIST_W-1:0];
  assign hund_prod  = dist_sat * DIV100_MUL;
  assign hund_digit = hund_prod[DIV100_SHR +: DIGIT_W];
  assign rem_val    = REM_W'(dist_sat - DIST_W'(hund_digit) * DIST_W'(HUNDRED));

  assign tens_prod   = c_rem * DIV10_MUL;
  assign tens_digit  = tens_prod[DIV10_SHR +: DIGIT_W];
  assign units_digit = DIGIT_W'(c_rem - REM_W'(tens_digit) * REM_W'(TEN));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      period_top <= PERIOD_TOP_RST;
      scale_q16  <= SCALE_Q16_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_reg_t'(cfg.index))
        REG_PERIOD_TOP: period_top <= cfg.data;
        REG_SCALE_Q16:  scale_q16  <= cfg.data;
        default: ;
      endcase
    end
  end

  // edge detect and tick counter
  always_ff @(posedge clk) begin
    if (rst) begin
      measuring  <= 1'b0;
      tick_count <= '0;
      last_echo  <= 1'b0;
    end else if (in_fire) begin
      last_echo <= tick.echo_level;
      if (rising) begin
        tick_count <= '0;
        measuring  <= 1'b1;
      end else if (falling) begin
        measuring <= 1'b0;
      end else if (measuring) begin
        tick_count <= count_next;
      end
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (ready_a) a_valid <= in_fire && falling && measuring;
      if (ready_b) b_valid <= a_valid;
      if (ready_c) c_valid <= b_valid;
      if (ready_o) o_valid <= c_valid;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (ready_a) a_ticks <= tick_count;
    if (ready_b) begin
      b_ticks <= a_ticks;
      b_prod  <= a_ticks * scale_q16;
    end
    if (ready_c) begin
      c_ticks <= b_ticks;
      c_dist  <= dist_sat;
      c_hund  <= hund_digit;
      c_rem   <= rem_val;
    end
    if (ready_o) begin
      meas.elapsed_ticks <= c_ticks;
      meas.distance_cm   <= c_dist;
      meas.hundreds_char <= ASCII_ZERO + CHAR_W'(c_hund);
      meas.tens_char     <= ASCII_ZERO + CHAR_W'(tens_digit);
      meas.units_char    <= ASCII_ZERO + CHAR_W'(units_digit);
    end
  end

  a_rise_restarts: assert property (@(posedge clk) disable iff (rst)
    in_fire && rising |=> measuring && tick_count == '0)
    else $error("rising edge did not restart the count");

  a_fall_captures: assert property (@(posedge clk) disable iff (rst)
    in_fire && falling && measuring |=> a_valid && a_ticks == $past(tick_count))
    else $error("falling edge did not capture the count");

  a_fall_stops: assert property (@(posedge clk) disable iff (rst)
    in_fire && falling |=> !measuring)
    else $error("counting continued past the falling edge");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !tick.ready |-> a_valid && b_valid && c_valid && o_valid)
    else $error("input stalled with room in the pipeline");

  a_digits_match: assert property (@(posedge clk) disable iff (rst)
    meas.valid |-> meas.distance_cm <= DIST_MAX
      && meas.hundreds_char >= ASCII_ZERO && meas.hundreds_char <= ASCII_ZERO + 6'd9
      && meas.tens_char >= ASCII_ZERO && meas.tens_char <= ASCII_ZERO + 6'd9
      && meas.units_char >= ASCII_ZERO && meas.units_char <= ASCII_ZERO + 6'd9)
    else $error("distance or digit out of range");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for echo_pulse_distance_meter_core: directed table, random pulse trains
// predicts results from its tick counter model or typed rows; depends on epdm_pkg and epdm_if.sv
module tb_top;
  import epdm_pkg::*;

  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [CHAR_W-1:0] CH0 = ASCII_ZERO;
  localparam logic [CHAR_W-1:0] CH9 = ASCII_ZERO + 6'd9;

  typedef struct packed {
    logic [TICK_W-1:0] ticks;
    logic [DIST_W-1:0] dist_cm;
    logic [CHAR_W-1:0] hund;
    logic [CHAR_W-1:0] tens;
    logic [CHAR_W-1:0] units;
  } range_rec_t;

  typedef enum logic {ROW_LEVEL, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    cfg_reg_t          sel;
    logic [15:0]       value;
    logic              level;
    int unsigned       count;
    bit                typed;
    range_rec_t        want;
  } row_t;

  localparam range_rec_t NO_REC = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;

  epdm_cfg_if    cfg_ch();
  epdm_echo_if   echo_ch();
  epdm_result_if meas_ch();

  echo_pulse_distance_meter_core u_dut (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_ch),
    .tick (echo_ch),
    .meas (meas_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state and register copies
  logic [TICK_W-1:0]  top_q   = PERIOD_TOP_RST;
  logic [SCALE_W-1:0] scale_q = SCALE_Q16_RST;
  logic [TICK_W-1:0]  count_q = '0;
  bit                 echo_on = 1'b0;
  logic               prev_level = 1'b0;

  range_rec_t range_expect[$];

  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  bit          rx_hold = 1'b0;
  bit          pressure_go = 1'b0;
  int unsigned rx_gap = 0;
  int unsigned ticks_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned results_seen = 0;
  int unsigned bad_count = 0;
  int unsigned stall_cycles = 0;

  row_t plan [23] = '{
    '{ROW_LEVEL, REG_PERIOD_TOP, 16'd0,     1'b0, 3,     1'b0, NO_REC},
    '{ROW_LEVEL, REG_PERIOD_TOP, 16'd0,     1'b1, 1,     1'b0, NO_REC},
    '{ROW_LEVEL, REG_PERIOD_TOP, 16'd0,     1'b0, 1,     1'b1, '{16'd0, 10'd0, CH0, CH0, CH0}},
    '{ROW_LEVEL, REG_PERIOD_TOP, 16'd0,     1'b1, 11,    1'b0, NO_REC},
    '{ROW_LEVEL, REG_PERIOD_TOP, 16'd0,     1'b0, 2,     1'b1, '{16'd10, 10'd0, CH0, CH0, CH0}},
    '{ROW_CFG,   REG_PERIOD_TOP, 16'd65535, 1'b0, 0,     1'b0, NO_REC},
    '{ROW_CFG,   REG_SCALE_Q16,  16'd65535, 1'b0, 0,     1'b0, NO_REC},
    '{ROW_LEVEL, REG_PERIOD_TOP, 16'd0,     1'b1, 1002,  1'b0, NO_REC},
    '{ROW_LEVEL, REG_PERIOD_TOP, 16'd0,     1'b0, 1,     1'b1, '{16'd1001, 10'd999, CH9, CH9, CH9}},
    '{ROW_LEVEL, REG_PERIOD_TOP, 16'd0,     1'b1, 20,    1'b0, NO_REC},
    '{ROW_LEVEL, REG_PERIOD_TOP, 16'd0,     1'b0, 1,     1'b0, NO_REC},
    '{ROW_CFG,   REG_SCALE_Q16,  16'd0,     1'b0, 0,     1'b0, NO_REC},
    '{ROW_LEVEL, REG_PERIOD_TOP, 16'd0,     1'b1, 5,     1'b0, NO_REC},
    '{ROW_LEVEL, REG_PERIOD_TOP, 16'd0,     1'b0, 1,     1'b1, '{16'd4, 10'd0, CH0, CH0, CH0}},
    '{ROW_CFG,   REG_PERIOD_TOP, 16'd1,     1'b0, 0,     1'b0, NO_REC},
    '{ROW_CFG,   REG_SCALE_Q16,  16'd40000, 1'b0, 0,     1'b0, NO_REC},
    '{ROW_LEVEL, REG_PERIOD_TOP, 16'd0,     1'b1, 6,     1'b0, NO_REC},
    '{ROW_LEVEL, REG_PERIOD_TOP, 16'd0,     1'b0, 1,     1'b0, NO_REC},
    '{ROW_CFG,   REG_PERIOD_TOP, 16'd300,   1'b0, 0,     1'b0, NO_REC},
    '{ROW_LEVEL, REG_PERIOD_TOP, 16'd0,     1'b1, 60,    1'b0, NO_REC},
    '{ROW_CFG,   REG_PERIOD_TOP, 16'd50,    1'b0, 0,     1'b0, NO_REC},
    '{ROW_LEVEL, REG_PERIOD_TOP, 16'd0,     1'b1, 3,     1'b0, NO_REC},
    '{ROW_LEVEL, REG_PERIOD_TOP, 16'd0,     1'b0, 2,     1'b0, NO_REC}
  };

  function automatic int unsigned draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  // one timer tick through the distance predictor
  task automatic measure_tick(input logic lvl, output bit hit, output range_rec_t rec);
    logic [31:0] prod;
    int unsigned cm;
    hit = 1'b0;
    rec = '0;
    if (lvl && !prev_level) begin
      count_q = '0;
      echo_on = 1'b1;
    end else if (!lvl && prev_level) begin
      if (echo_on) begin
        prod = count_q * scale_q;
        cm = prod >> 16;
        if (cm > DIST_MAX) cm = DIST_MAX;
        rec.ticks   = count_q;
        rec.dist_cm = DIST_W'(cm);
        rec.hund    = ASCII_ZERO + CHAR_W'(cm / 100);
        rec.tens    = ASCII_ZERO + CHAR_W'((cm % 100) / 10);
        rec.units   = ASCII_ZERO + CHAR_W'(cm % 10);
        hit = 1'b1;
      end
      echo_on = 1'b0;
    end else if (echo_on) begin
      count_q = (count_q >= top_q) ? '0 : count_q + 1'b1;
    end
    prev_level = lvl;
  endtask

  task automatic send_tick(input logic lvl, input bit fixed, input range_rec_t fixed_rec);
    int unsigned g;
    bit hit;
    range_rec_t rec;
    g = draw_gap(tx_calm);
    if (g > 0) begin
      echo_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    echo_ch.valid      <= 1'b1;
    echo_ch.echo_level <= lvl;
    @(posedge clk);
    while (!echo_ch.ready) @(posedge clk);
    measure_tick(lvl, hit, rec);
    if (hit) range_expect.push_back(fixed ? fixed_rec : rec);
    ticks_sent++;
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] val);
    echo_ch.valid <= 1'b0;
    while (range_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= sel;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (sel)
      REG_PERIOD_TOP: top_q = val;
      REG_SCALE_Q16:  scale_q = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // receiver side
  always @(posedge clk) begin
    if (rst) begin
      rx_gap = 0;
      meas_ch.ready <= 1'b0;
    end else begin
      if (meas_ch.valid && meas_ch.ready) rx_gap = draw_gap(rx_calm);
      else if (rx_gap > 0) rx_gap = rx_gap - 1;
      meas_ch.ready <= (rx_gap == 0) && !rx_hold;
    end
  end

  // long output hold-off so the pipeline backs up into the echo input
  initial begin
    wait (pressure_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) begin
      @(posedge clk);
      if (echo_ch.valid && !echo_ch.ready) stall_cycles++;
    end
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin : meas_check
    range_rec_t got;
    range_rec_t want;
    if (!rst && meas_ch.valid && meas_ch.ready) begin
      got.ticks   = meas_ch.elapsed_ticks;
      got.dist_cm = meas_ch.distance_cm;
      got.hund    = meas_ch.hundreds_char;
      got.tens    = meas_ch.tens_char;
      got.units   = meas_ch.units_char;
      results_seen++;
      if (range_expect.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("%0t: unexpected range transaction ticks %0d cm %0d chars %0d %0d %0d",
                   $realtime, got.ticks, got.dist_cm, got.hund, got.tens, got.units);
      end else begin
        want = range_expect.pop_front();
        if (got.ticks !== want.ticks || got.dist_cm !== want.dist_cm ||
            got.hund !== want.hund || got.tens !== want.tens || got.units !== want.units) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: mismatch exp %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                     $realtime, want.ticks, want.dist_cm, want.hund, want.tens, want.units,
                     got.ticks, got.dist_cm, got.hund, got.tens, got.units);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("echo_pulse_distance_meter_core verification failed");
    $finish;
  end

  initial begin
    int unsigned r;
    int unsigned lo;
    int unsigned hi;
    int unsigned n_pulses;
    logic [15:0] per;
    logic [15:0] scl;
    echo_ch.valid      <= 1'b0;
    echo_ch.echo_level <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= REG_PERIOD_TOP;
    cfg_ch.data        <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].sel, plan[i].value);
      end else begin
        tx_calm = plan[i].count > 64;
        repeat (plan[i].count) send_tick(plan[i].level, plan[i].typed, plan[i].want);
      end
    end

    // random pulse trains, one register setting per phase
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          per = 16'($urandom_range(2, 30));
          scl = 16'($urandom_range(20000, 65535));
        end
        1: begin
          per = 16'd65535;
          scl = 16'd65535;
        end
        2: begin
          per = 16'd1;
          scl = 16'($urandom_range(0, 65535));
        end
        3: begin
          per = 16'($urandom_range(1, 65535));
          scl = 16'($urandom_range(0, 65535));
        end
        default: begin
          per = PERIOD_TOP_RST;
          scl = SCALE_Q16_RST;
        end
      endcase
      write_reg(REG_PERIOD_TOP, per);
      write_reg(REG_SCALE_Q16, scl);
      rx_calm <= (ph == 0);
      n_pulses = (ph == 1) ? 24 : 4;
      if (ph == 1) pressure_go = 1'b1;
      for (int p = 0; p < n_pulses; p++) begin
        r = $urandom_range(0, 15);
        if (ph == 1) begin
          tx_calm = 1'b1;
          send_tick(1'b0, 1'b0, NO_REC);
          repeat ($urandom_range(1, 2)) send_tick(1'b1, 1'b0, NO_REC);
        end else if (r == 0) begin
          tx_calm = (ph == 0);
          repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)), 1'b0, NO_REC);
        end else begin
          lo = $urandom_range(1, 4);
          hi = (r == 1) ? $urandom_range(30, 90) : $urandom_range(1, 20);
          tx_calm = (ph == 0) || (r == 1);
          repeat (lo) send_tick(1'b0, 1'b0, NO_REC);
          repeat (hi) send_tick(1'b1, 1'b0, NO_REC);
        end
      end
    end
    tx_calm = 1'b0;
    send_tick(1'b0, 1'b0, NO_REC);
    echo_ch.valid <= 1'b0;

    while (range_expect.size() != 0) @(posedge clk);
    repeat (4 * DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d echo ticks, %0d register writes and %0d range results",
             ticks_sent, cfg_writes, results_seen);
    $display("output held off %0d cycles, echo input stalled %0d of them, %0d mismatches",
             HOLD_CYCLES, stall_cycles, bad_count);
    if (bad_count == 0) begin
      $display("echo_pulse_distance_meter_core verification clean");
    end else begin
      $display("echo_pulse_distance_meter_core verification failed");
    end
    $finish;
  end

endmodule
